### src/qmm_pkg.sv
`timescale 1ns / 1ps

package qmm_pkg;

  // Field widths.
  localparam int unsigned ModeW  = 2;
  localparam int unsigned SpeedW = 10;
  localparam int unsigned CorrW  = 12;
  localparam int unsigned RampW  = 8;
  localparam int unsigned MotorN = 4;

  // Signed width that holds throttle plus every correction term without overflow.
  localparam int unsigned SumW = 15;

  // Bus widths: fields packed from the lowest bit up, padded to whole bytes.
  localparam int unsigned InBits   = ModeW + SpeedW + 4 * CorrW;
  localparam int unsigned InDataW  = ((InBits + 7) / 8) * 8;
  localparam int unsigned OutBits  = MotorN * SpeedW + 1;
  localparam int unsigned OutDataW = ((OutBits + 7) / 8) * 8;

  // Configuration register indexes.
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 10;

  typedef enum logic [CfgAddrW-1:0] {
    REG_MAX_SPEED    = 2'd0,
    REG_YAW_LIMIT    = 2'd1,
    REG_MIN_THROTTLE = 2'd2,
    REG_RAMP_STEP    = 2'd3
  } cfg_reg_e;

  // Reset values.
  localparam logic [SpeedW-1:0] MaxSpeedRst    = 10'd700;
  localparam logic [SpeedW-1:0] YawLimitRst    = 10'd100;
  localparam logic [SpeedW-1:0] MinThrottleRst = 10'd50;
  localparam logic [RampW-1:0]  RampStepRst    = 8'd2;
  localparam logic [SpeedW-1:0] SpeedRst       = 10'd200;

  typedef enum logic [ModeW-1:0] {
    MODE_IDLE   = 2'd0,
    MODE_NORMAL = 2'd1,
    MODE_FIX_HT = 2'd2,
    MODE_FAIL   = 2'd3
  } mode_e;

  typedef struct packed {
    logic [SpeedW-1:0] max_speed;
    logic [SpeedW-1:0] yaw_limit;
    logic [SpeedW-1:0] min_throttle;
    logic [RampW-1:0]  ramp_step;
  } cfg_t;

  // Members listed from the highest bit down, so mode lands in the lowest bits.
  typedef struct packed {
    logic signed [CorrW-1:0] height_corr;
    logic signed [CorrW-1:0] yaw_corr;
    logic signed [CorrW-1:0] roll_corr;
    logic signed [CorrW-1:0] pitch_corr;
    logic [SpeedW-1:0]       throttle;
    mode_e                   mode;
  } in_item_t;

  typedef struct packed {
    logic              fail_done;
    logic [SpeedW-1:0] rear_right_speed;
    logic [SpeedW-1:0] front_right_speed;
    logic [SpeedW-1:0] rear_left_speed;
    logic [SpeedW-1:0] front_left_speed;
  } out_item_t;

  typedef logic [MotorN-1:0][SpeedW-1:0] speeds_t;

endpackage

### src/qmm_cfg.sv
`timescale 1ns / 1ps

module qmm_cfg (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [qmm_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [qmm_pkg::CfgDataW-1:0] cfg_data_i,
  output qmm_pkg::cfg_t           cfg_o
);
  import qmm_pkg::*;

  cfg_t cfg_q;

  // Register file, written one register at a time.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_speed    <= MaxSpeedRst;
      cfg_q.yaw_limit    <= YawLimitRst;
      cfg_q.min_throttle <= MinThrottleRst;
      cfg_q.ramp_step    <= RampStepRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_MAX_SPEED:    cfg_q.max_speed    <= cfg_data_i[SpeedW-1:0];
        REG_YAW_LIMIT:    cfg_q.yaw_limit    <= cfg_data_i[SpeedW-1:0];
        REG_MIN_THROTTLE: cfg_q.min_throttle <= cfg_data_i[SpeedW-1:0];
        REG_RAMP_STEP:    cfg_q.ramp_step    <= cfg_data_i[RampW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### src/qmm_mix.sv
`timescale 1ns / 1ps

module qmm_mix (
  input  qmm_pkg::in_item_t  item_i,
  input  qmm_pkg::cfg_t      cfg_i,
  input  qmm_pkg::speeds_t   speeds_i,
  output qmm_pkg::out_item_t result_o
);
  import qmm_pkg::*;

  logic signed [SumW-1:0] thr_s;
  logic signed [SumW-1:0] pitch_s;
  logic signed [SumW-1:0] roll_s;
  logic signed [SumW-1:0] yaw_s;
  logic signed [SumW-1:0] yaw_cl;
  logic signed [SumW-1:0] lim_s;
  logic signed [SumW-1:0] add_s;
  logic signed [SumW-1:0] ramp_s;
  logic signed [SumW-1:0] max_s;
  logic signed [SumW-1:0] raw [MotorN];
  logic [SpeedW-1:0]      spd [MotorN];
  logic                   all_low;
  logic                   thr_cut;

  // Operands extended to the common signed width.
  always_comb begin
    thr_s   = $signed({{(SumW-SpeedW){1'b0}}, item_i.throttle});
    pitch_s = SumW'(item_i.pitch_corr);
    roll_s  = SumW'(item_i.roll_corr);
    yaw_s   = SumW'(item_i.yaw_corr);
    lim_s   = $signed({{(SumW-SpeedW){1'b0}}, cfg_i.yaw_limit});
    ramp_s  = $signed({{(SumW-RampW){1'b0}}, cfg_i.ramp_step});
    max_s   = $signed({{(SumW-SpeedW){1'b0}}, cfg_i.max_speed});
    add_s   = (item_i.mode == MODE_FIX_HT) ? SumW'(item_i.height_corr) : '0;
  end

  // Symmetric clamp on the yaw term.
  always_comb begin
    if (yaw_s > lim_s) begin
      yaw_cl = lim_s;
    end else if (yaw_s < -lim_s) begin
      yaw_cl = -lim_s;
    end else begin
      yaw_cl = yaw_s;
    end
  end

  // Raw motor values per mode, before the speed clamp.
  always_comb begin
    all_low = 1'b1;
    for (int i = 0; i < MotorN; i++) begin
      raw[i] = '0;
    end
    unique case (item_i.mode)
      MODE_IDLE: begin
        all_low = 1'b0;
      end
      MODE_FAIL: begin
        for (int i = 0; i < MotorN; i++) begin
          raw[i] = $signed({{(SumW-SpeedW){1'b0}}, speeds_i[i]}) - ramp_s;
          if (raw[i] > 0) begin
            all_low = 1'b0;
          end
        end
      end
      default: begin
        all_low = 1'b0;
        raw[0]  = thr_s + pitch_s - roll_s + yaw_cl + add_s;
        raw[1]  = thr_s - pitch_s - roll_s - yaw_cl + add_s;
        raw[2]  = thr_s + pitch_s + roll_s - yaw_cl + add_s;
        raw[3]  = thr_s - pitch_s + roll_s + yaw_cl + add_s;
      end
    endcase
  end

  // Clamp to 0..max_speed, then the low-throttle cut.
  assign thr_cut = (item_i.throttle < cfg_i.min_throttle);

  always_comb begin
    for (int i = 0; i < MotorN; i++) begin
      if (thr_cut || raw[i] <= 0) begin
        spd[i] = '0;
      end else if (raw[i] > max_s) begin
        spd[i] = cfg_i.max_speed;
      end else begin
        spd[i] = raw[i][SpeedW-1:0];
      end
    end
  end

  assign result_o.front_left_speed  = spd[0];
  assign result_o.rear_left_speed   = spd[1];
  assign result_o.front_right_speed = spd[2];
  assign result_o.rear_right_speed  = spd[3];
  assign result_o.fail_done         = all_low;

endmodule

### src/quad_motor_mixer_failsafe.sv
`timescale 1ns / 1ps

// Four-motor X-frame mixer with a fail-safe ramp-down.
// The slave stream carries one control tick per item: mode, throttle and the
// pitch, roll, yaw and height corrections. The master stream returns one item
// per tick with the four clamped motor speeds and the fail-done flag.
// An accepted item is held in the input register and its result is registered
// into the result register once that register frees up, so a stalled receiver
// can delay it. The mixing is a single pass of add and clamp logic between the
// two registers, so one item is taken every cycle while the receiver keeps up.
// The stored motor speeds, used by the fail ramp, are updated at the same edge
// that loads the result register, so back-to-back fail ticks see each other.
// Reset loads the register defaults and sets every stored speed to 200; both
// registers come up empty. When the receiver stalls, the result holds and the
// input register fills; tready then drops until the result is taken.
// Configuration writes take effect at the next edge; the user must make them
// only while the block is idle, as the block itself does not enforce this.
module quad_motor_mixer_failsafe (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Slave stream, tdata from bit 0: mode, throttle, pitch_corr, roll_corr,
  // yaw_corr, height_corr, zero pad.
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [qmm_pkg::InDataW-1:0]  s_axis_tdata,
  // Master stream, tdata from bit 0: front_left_speed, rear_left_speed,
  // front_right_speed, rear_right_speed, fail_done, zero pad.
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [qmm_pkg::OutDataW-1:0] m_axis_tdata,
  // Configuration write port.
  input  logic                         cfg_we_i,
  input  logic [qmm_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [qmm_pkg::CfgDataW-1:0] cfg_data_i
);
  import qmm_pkg::*;

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t out_q;
  logic      out_valid_q;
  out_item_t result;
  speeds_t   speeds_q;
  logic      advance;
  logic      in_take;

  qmm_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  qmm_mix u_mix (
    .item_i   (in_q),
    .cfg_i    (cfg),
    .speeds_i (speeds_q),
    .result_o (result)
  );

  // Handshake: the result register frees up when empty or taken.
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_item_t'(s_axis_tdata[InBits-1:0]);
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      out_q <= result;
    end
  end

  // Stored speeds follow every result that is produced.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MotorN; i++) begin
        speeds_q[i] <= SpeedRst;
      end
    end else if (advance && in_valid_q) begin
      speeds_q[0] <= result.front_left_speed;
      speeds_q[1] <= result.rear_left_speed;
      speeds_q[2] <= result.front_right_speed;
      speeds_q[3] <= result.rear_right_speed;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW-OutBits){1'b0}}, out_q};

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import qmm_pkg::*;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // From bit 0: mode, throttle, pitch_corr, roll_corr, yaw_corr, height_corr, zero pad.
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // From bit 0: front_left_speed, rear_left_speed, front_right_speed,
  // rear_right_speed, fail_done, zero pad.
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i      = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i    = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  quad_motor_mixer_failsafe dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Mirror of the block's registers and stored motor speeds.
  logic [SpeedW-1:0] cfg_max_speed;
  logic [SpeedW-1:0] cfg_yaw_limit;
  logic [SpeedW-1:0] cfg_min_throttle;
  logic [RampW-1:0]  cfg_ramp_step;
  logic [SpeedW-1:0] held_speed [MotorN];

  in_item_t  ticks_to_send [$];
  out_item_t speeds_due [$];
  int        mismatches = 0;
  bit        tick_taken = 1'b0;
  bit        steady     = 1'b0;
  out_item_t got_speeds;
  out_item_t want_speeds;

  // Mix one control tick into four motor speeds and update the held speeds.
  function automatic out_item_t mix_tick(in_item_t it);
    int raw [MotorN];
    int thr, pit, rol, yaw, hgt, lift, lim, spd;
    logic all_low;
    out_item_t res;
    thr = it.throttle;
    pit = $signed(it.pitch_corr);
    rol = $signed(it.roll_corr);
    yaw = $signed(it.yaw_corr);
    hgt = $signed(it.height_corr);
    lim = cfg_yaw_limit;
    if (yaw > lim) yaw = lim;
    else if (yaw < -lim) yaw = -lim;
    all_low = 1'b0;
    case (it.mode)
      MODE_IDLE: begin
        foreach (raw[i]) raw[i] = 0;
      end
      MODE_FAIL: begin
        all_low = 1'b1;
        foreach (raw[i]) begin
          raw[i] = int'(held_speed[i]) - int'(cfg_ramp_step);
          if (raw[i] > 0) all_low = 1'b0;
        end
      end
      default: begin
        lift = (it.mode == MODE_FIX_HT) ? hgt : 0;
        raw[0] = thr + pit - rol + yaw + lift;
        raw[1] = thr - pit - rol - yaw + lift;
        raw[2] = thr + pit + rol - yaw + lift;
        raw[3] = thr - pit + rol + yaw + lift;
      end
    endcase
    // Saturate, then apply the low-throttle cut.
    foreach (raw[i]) begin
      if (raw[i] <= 0) spd = 0;
      else if (raw[i] > int'(cfg_max_speed)) spd = cfg_max_speed;
      else spd = raw[i];
      if (it.throttle < cfg_min_throttle) spd = 0;
      held_speed[i] = spd[SpeedW-1:0];
    end
    res.front_left_speed  = held_speed[0];
    res.rear_left_speed   = held_speed[1];
    res.front_right_speed = held_speed[2];
    res.rear_right_speed  = held_speed[3];
    res.fail_done         = all_low;
    return res;
  endfunction

  function automatic in_item_t make_tick(mode_e m, int thr, int p, int r, int y, int h);
    in_item_t it;
    it.mode        = m;
    it.throttle    = thr[SpeedW-1:0];
    it.pitch_corr  = p[CorrW-1:0];
    it.roll_corr   = r[CorrW-1:0];
    it.yaw_corr    = y[CorrW-1:0];
    it.height_corr = h[CorrW-1:0];
    return it;
  endfunction

  // Half the corrections span the full range, the rest stay near zero.
  function automatic int rand_corr();
    if ($urandom_range(1)) return $urandom_range(4095);
    return int'($urandom_range(600)) - 300;
  endfunction

  // Mostly above the cut level so that the mixing shows through.
  function automatic int rand_throttle();
    if ($urandom_range(99) < 80) return $urandom_range(1023, int'(cfg_min_throttle));
    return $urandom_range(1023);
  endfunction

  function automatic bit go_now();
    return steady || ($urandom_range(99) >= 13);
  endfunction

  task automatic send(mode_e m, int thr, int p, int r, int y, int h);
    ticks_to_send.push_back(make_tick(m, thr, p, r, y, h));
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Register write; the block is idle whenever this is called.
  task automatic write_reg(cfg_reg_e idx, int unsigned val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val[CfgDataW-1:0];
    case (idx)
      REG_MAX_SPEED:    cfg_max_speed    = val[SpeedW-1:0];
      REG_YAW_LIMIT:    cfg_yaw_limit    = val[SpeedW-1:0];
      REG_MIN_THROTTLE: cfg_min_throttle = val[SpeedW-1:0];
      REG_RAMP_STEP:    cfg_ramp_step    = val[RampW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Wait until every item is sent and every result is back, plus the latency.
  task automatic wait_idle();
    while (ticks_to_send.size() != 0 || s_axis_tvalid || speeds_due.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic queue_random(int count);
    int n;
    int run;
    n = 0;
    while (n < count) begin
      if ($urandom_range(99) < 25) begin
        // A run of fail ticks so the ramp can reach zero.
        run = $urandom_range(12, 1);
        repeat (run)
          send(MODE_FAIL, rand_throttle(), rand_corr(), rand_corr(), rand_corr(),
               rand_corr());
        n += run;
      end else begin
        send(mode_e'($urandom_range(3)), rand_throttle(), rand_corr(), rand_corr(),
             rand_corr(), rand_corr());
        n++;
      end
    end
  endtask

  // Sender and receiver, driven at the falling edge.
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || tick_taken) begin
      if (ticks_to_send.size() != 0 && go_now()) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= InDataW'(ticks_to_send.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    tick_taken = 1'b0;
    m_axis_tready <= go_now();
  end

  // Check each result, then predict for each item taken at this edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_speeds = out_item_t'(m_axis_tdata[OutBits-1:0]);
        if (speeds_due.size() == 0) begin
          $display("%0t ns: result with none expected, actual %h", $time, got_speeds);
          mismatches++;
        end else begin
          want_speeds = speeds_due.pop_front();
          check_field("front_left_speed", want_speeds.front_left_speed,
                      got_speeds.front_left_speed);
          check_field("rear_left_speed", want_speeds.rear_left_speed,
                      got_speeds.rear_left_speed);
          check_field("front_right_speed", want_speeds.front_right_speed,
                      got_speeds.front_right_speed);
          check_field("rear_right_speed", want_speeds.rear_right_speed,
                      got_speeds.rear_right_speed);
          check_field("fail_done", want_speeds.fail_done, got_speeds.fail_done);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        speeds_due.push_back(mix_tick(in_item_t'(s_axis_tdata[InBits-1:0])));
        tick_taken = 1'b1;
      end
    end
  end

  // Stimulus phases.
  initial begin
    int unsigned pick;
    cfg_max_speed    = MaxSpeedRst;
    cfg_yaw_limit    = YawLimitRst;
    cfg_min_throttle = MinThrottleRst;
    cfg_ramp_step    = RampStepRst;
    foreach (held_speed[i]) held_speed[i] = SpeedRst;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: ramp from the reset speeds, extremes, clamps and cuts.
    send(MODE_FAIL, 500, 0, 0, 0, 0);
    send(MODE_NORMAL, 1023, 2047, -2048, 2047, 2047);
    send(MODE_NORMAL, 50, -2048, 2047, -2048, -2048);
    send(MODE_NORMAL, 49, 100, 0, 0, 0);
    send(MODE_FIX_HT, 300, 0, 0, 0, 2047);
    send(MODE_FIX_HT, 400, 50, -30, 70, 25);
    send(MODE_NORMAL, 400, 10, 20, 150, 0);
    send(MODE_NORMAL, 400, -10, 20, -150, 0);
    send(MODE_NORMAL, 300, 0, 0, 0, 0);
    // Ramp under a throttle cut: the flag still rises once the ramp hits zero.
    send(MODE_FAIL, 0, 0, 0, 0, 0);
    send(MODE_FAIL, 0, 0, 0, 0, 0);
    send(MODE_IDLE, 1023, 2047, 2047, 2047, 2047);
    send(MODE_FAIL, 1023, -1, -1, -1, -1);
    wait_idle();

    // Widest clamp, no yaw, no cut, largest ramp step.
    write_reg(REG_MAX_SPEED, 1023);
    write_reg(REG_YAW_LIMIT, 0);
    write_reg(REG_MIN_THROTTLE, 0);
    write_reg(REG_RAMP_STEP, 255);
    send(MODE_NORMAL, 1023, 0, 0, 2047, 0);
    repeat (5) send(MODE_FAIL, 0, 0, 0, 0, 0);
    send(MODE_NORMAL, 0, 5, 0, 0, 0);
    wait_idle();

    // Full yaw range and a zero ramp step that holds the speeds.
    write_reg(REG_YAW_LIMIT, 1023);
    write_reg(REG_RAMP_STEP, 0);
    send(MODE_NORMAL, 600, 0, 0, -2048, 0);
    send(MODE_FAIL, 600, 0, 0, 0, 0);
    send(MODE_IDLE, 600, 0, 0, 0, 0);
    send(MODE_FAIL, 600, 0, 0, 0, 0);
    wait_idle();
    write_reg(REG_MIN_THROTTLE, 1023);
    send(MODE_NORMAL, 1023, 0, 0, 0, 0);
    send(MODE_NORMAL, 1022, 0, 0, 0, 0);
    wait_idle();

    // Random phases, each under fresh settings.
    for (int ph = 0; ph < 6; ph++) begin
      pick = $urandom_range(9);
      write_reg(REG_MAX_SPEED, pick == 0 ? 0 : pick == 1 ? 1023 : $urandom_range(1023));
      pick = $urandom_range(9);
      write_reg(REG_YAW_LIMIT, pick == 0 ? 0 : pick == 1 ? 1023 : $urandom_range(400));
      pick = $urandom_range(9);
      write_reg(REG_MIN_THROTTLE, pick == 0 ? 0 : pick == 1 ? 1023 : $urandom_range(200));
      pick = $urandom_range(9);
      write_reg(REG_RAMP_STEP, pick == 0 ? 0 : pick == 1 ? 255 :
                $urandom_range(40, 1) + ($urandom_range(1) ? 256 : 0));
      steady = (ph == 2);
      queue_random(85);
      wait_idle();
    end
    steady = 1'b0;

    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // Watchdog.
  initial begin
    #1000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

### filelist.f
src/qmm_pkg.sv
src/qmm_cfg.sv
src/qmm_mix.sv
src/quad_motor_mixer_failsafe.sv
bench/tb.sv
